@@ design/fcfs_pkg.sv @@
// Shared constants, types and helper functions of the FAT chain file stream.
`default_nettype none
package fcfs_pkg;

    localparam int NUM_BLOCKS      = 1024;
    localparam int BLOCK_BYTES     = 1024;
    localparam int RESERVED_BLOCKS = 4;

    localparam int OP_W     = 3;
    localparam int START_W  = 10;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FAT_W    = 16;

    localparam int BLK_W  = $clog2(NUM_BLOCKS);
    localparam int OFS_W  = $clog2(BLOCK_BYTES);
    localparam int POS_W  = $clog2(BLOCK_BYTES + 1);
    localparam int STEP_W = $clog2(NUM_BLOCKS + 1);
    localparam int SCN_W  = (POS_W > STEP_W) ? POS_W : STEP_W;
    localparam int ADDR_W = $clog2(NUM_BLOCKS * BLOCK_BYTES);

    localparam logic [FAT_W-1:0] FAT_FREE = 16'hFFFF;
    localparam logic [FAT_W-1:0] FAT_END  = 16'h0000;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN_RD = 3'd0,
        OP_OPEN_WR = 3'd1,
        OP_OPEN_AP = 3'd2,
        OP_CREATE  = 3'd3,
        OP_PUT     = 3'd4,
        OP_GET     = 3'd5,
        OP_DELETE  = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_READ_ONLY = 3'd1,
        ST_DISK_FULL = 3'd2,
        ST_EOF       = 3'd3,
        ST_NO_FILE   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_READ   = 2'd1,
        MODE_WRITE  = 2'd2,
        MODE_APPEND = 2'd3
    } mode_t;

    // Write and read request of the allocation table memory.
    typedef struct packed {
        logic             we;
        logic [BLK_W-1:0] waddr;
        logic [FAT_W-1:0] wdata;
        logic [BLK_W-1:0] raddr;
    } fat_req_t;

    // Write and read request of the byte store memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } byte_req_t;

    // Byte address of an offset within a block.
    function automatic logic [ADDR_W-1:0] byte_addr(input logic [BLK_W-1:0] blk,
                                                    input logic [OFS_W-1:0] ofs);
        return ADDR_W'(blk) * ADDR_W'(BLOCK_BYTES) + ADDR_W'(ofs);
    endfunction

    // True when a table entry links to a further block.
    function automatic logic has_link(input logic [FAT_W-1:0] v);
        return (v != FAT_END) && (v != FAT_FREE) && (v < FAT_W'(NUM_BLOCKS));
    endfunction

    // Formatted table layout: block one links to two, blocks zero, two and three end.
    function automatic logic [FAT_W-1:0] fmt_entry(input logic [BLK_W-1:0] i);
        logic [FAT_W-1:0] v;
        v = FAT_FREE;
        if (i == BLK_W'(1)) begin
            v = FAT_W'(2);
        end else if (i == BLK_W'(0) || i == BLK_W'(2) || i == BLK_W'(3)) begin
            v = FAT_END;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ design/fcfs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module fcfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ design/fcfs_ctrl.sv @@
// Sequencer that reads, modifies and writes back the table and byte store.
`default_nettype none
module fcfs_ctrl (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [fcfs_pkg::OP_W-1:0]       s_op,
    input  wire logic [fcfs_pkg::START_W-1:0]    s_start_block,
    input  wire logic [fcfs_pkg::BYTE_W-1:0]     s_data_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [fcfs_pkg::STATUS_W-1:0]   m_status,
    output logic      [fcfs_pkg::BYTE_W-1:0]     m_read_byte,
    output logic      [fcfs_pkg::START_W-1:0]    m_block_number,
    output fcfs_pkg::fat_req_t                   fat_req,
    input  wire logic [fcfs_pkg::FAT_W-1:0]      fat_rdata,
    output fcfs_pkg::byte_req_t                  byte_req,
    input  wire logic [fcfs_pkg::BYTE_W-1:0]     byte_rdata
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CHK, S_WALK, S_ASCAN, S_SCAN, S_ALLOC, S_CLR,
        S_LINK, S_PUT_LNK, S_GET_LNK, S_GET_RD, S_DEL, S_DELC, S_DONE
    } state_t;

    state_t                            state_reg, state_next;
    fcfs_pkg::op_t                     op_reg, op_next;
    logic [fcfs_pkg::START_W-1:0]      sblk_reg, sblk_next;
    logic [fcfs_pkg::BYTE_W-1:0]       data_reg, data_next;
    fcfs_pkg::mode_t                   mode_reg, mode_next;
    logic [fcfs_pkg::BLK_W-1:0]        cur_reg, cur_next;
    logic [fcfs_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [fcfs_pkg::BLK_W-1:0]        walk_reg, walk_next;
    logic [fcfs_pkg::STEP_W-1:0]       steps_reg, steps_next;
    logic [fcfs_pkg::SCN_W-1:0]        scan_reg, scan_next;
    logic                              svld_reg, svld_next;
    fcfs_pkg::status_t                 res_status_reg, res_status_next;
    logic [fcfs_pkg::BYTE_W-1:0]       res_rb_reg, res_rb_next;
    logic                              m_valid_reg, m_valid_next;
    logic [fcfs_pkg::STATUS_W-1:0]     m_status_reg, m_status_next;
    logic [fcfs_pkg::BYTE_W-1:0]       m_rb_reg, m_rb_next;
    logic [fcfs_pkg::START_W-1:0]      m_blk_reg, m_blk_next;
    logic                              fwd_vld_reg, fwd_vld_next;
    logic [fcfs_pkg::FAT_W-1:0]        fwd_data_reg, fwd_data_next;

    logic [fcfs_pkg::FAT_W-1:0]        fat_q;
    logic                              exists;
    logic [fcfs_pkg::BLK_W-1:0]        link_blk;
    logic [fcfs_pkg::SCN_W-1:0]        scan_prev;

    // A table write to the address read in the same cycle is forwarded.
    assign fat_q     = fwd_vld_reg ? fwd_data_reg : fat_rdata;
    assign exists    = (32'(sblk_reg) < fcfs_pkg::NUM_BLOCKS) && (fat_q != fcfs_pkg::FAT_FREE);
    assign link_blk  = fcfs_pkg::BLK_W'(fat_q);
    assign scan_prev = scan_reg - fcfs_pkg::SCN_W'(1);

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_read_byte    = m_rb_reg;
    assign m_block_number = m_blk_reg;

    // Next-state and memory request logic.
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        sblk_next       = sblk_reg;
        data_next       = data_reg;
        mode_next       = mode_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        walk_next       = walk_reg;
        steps_next      = steps_reg;
        scan_next       = scan_reg;
        svld_next       = svld_reg;
        res_status_next = res_status_reg;
        res_rb_next     = res_rb_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_rb_next       = m_rb_reg;
        m_blk_next      = m_blk_reg;
        fat_req         = '0;
        byte_req        = '0;

        unique case (state_reg)
            S_INIT: begin
                fat_req.we    = 1'b1;
                fat_req.waddr = fcfs_pkg::BLK_W'(scan_reg);
                fat_req.wdata = fcfs_pkg::fmt_entry(fcfs_pkg::BLK_W'(scan_reg));
                scan_next     = scan_reg + fcfs_pkg::SCN_W'(1);
                if (scan_reg == fcfs_pkg::SCN_W'(fcfs_pkg::NUM_BLOCKS - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    op_next         = fcfs_pkg::op_t'(s_op);
                    sblk_next       = s_start_block;
                    data_next       = s_data_byte;
                    res_status_next = fcfs_pkg::ST_OK;
                    res_rb_next     = '0;
                    scan_next       = '0;
                    svld_next       = 1'b0;
                    state_next      = S_DONE;
                    unique case (fcfs_pkg::op_t'(s_op))
                        fcfs_pkg::OP_OPEN_RD, fcfs_pkg::OP_OPEN_WR,
                        fcfs_pkg::OP_OPEN_AP, fcfs_pkg::OP_DELETE: begin
                            fat_req.raddr = fcfs_pkg::BLK_W'(s_start_block);
                            state_next    = S_CHK;
                        end
                        fcfs_pkg::OP_CREATE: begin
                            state_next = S_SCAN;
                        end
                        fcfs_pkg::OP_PUT: begin
                            priority if (mode_reg == fcfs_pkg::MODE_NONE) begin
                                res_status_next = fcfs_pkg::ST_NO_FILE;
                            end else if (mode_reg == fcfs_pkg::MODE_READ) begin
                                res_status_next = fcfs_pkg::ST_READ_ONLY;
                            end else if (pos_reg < fcfs_pkg::POS_W'(fcfs_pkg::BLOCK_BYTES)) begin
                                byte_req.we    = 1'b1;
                                byte_req.waddr = fcfs_pkg::byte_addr(cur_reg,
                                                     fcfs_pkg::OFS_W'(pos_reg));
                                byte_req.wdata = s_data_byte;
                                pos_next       = pos_reg + fcfs_pkg::POS_W'(1);
                            end else begin
                                fat_req.raddr = cur_reg;
                                state_next    = S_PUT_LNK;
                            end
                        end
                        fcfs_pkg::OP_GET: begin
                            priority if (mode_reg == fcfs_pkg::MODE_NONE) begin
                                res_status_next = fcfs_pkg::ST_NO_FILE;
                            end else if (pos_reg < fcfs_pkg::POS_W'(fcfs_pkg::BLOCK_BYTES)) begin
                                byte_req.raddr = fcfs_pkg::byte_addr(cur_reg,
                                                     fcfs_pkg::OFS_W'(pos_reg));
                                state_next     = S_GET_RD;
                            end else begin
                                fat_req.raddr = cur_reg;
                                state_next    = S_GET_LNK;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Existence check of the start block.
            S_CHK: begin
                state_next = S_DONE;
                unique case (op_reg)
                    fcfs_pkg::OP_OPEN_RD: begin
                        if (exists) begin
                            cur_next  = fcfs_pkg::BLK_W'(sblk_reg);
                            pos_next  = '0;
                            mode_next = fcfs_pkg::MODE_READ;
                        end else begin
                            mode_next       = fcfs_pkg::MODE_NONE;
                            res_status_next = fcfs_pkg::ST_NO_FILE;
                        end
                    end
                    fcfs_pkg::OP_OPEN_WR: begin
                        if (exists) begin
                            cur_next  = fcfs_pkg::BLK_W'(sblk_reg);
                            pos_next  = '0;
                            mode_next = fcfs_pkg::MODE_WRITE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    fcfs_pkg::OP_OPEN_AP: begin
                        if (exists) begin
                            walk_next     = fcfs_pkg::BLK_W'(sblk_reg);
                            steps_next    = '0;
                            fat_req.raddr = fcfs_pkg::BLK_W'(sblk_reg);
                            state_next    = S_WALK;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    fcfs_pkg::OP_DELETE: begin
                        if (exists && 32'(sblk_reg) >= fcfs_pkg::RESERVED_BLOCKS) begin
                            walk_next     = fcfs_pkg::BLK_W'(sblk_reg);
                            steps_next    = '0;
                            fat_req.raddr = fcfs_pkg::BLK_W'(sblk_reg);
                            state_next    = S_DEL;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Follow the chain to its last block.
            S_WALK: begin
                if (fcfs_pkg::has_link(fat_q)
                        && steps_reg < fcfs_pkg::STEP_W'(fcfs_pkg::NUM_BLOCKS)) begin
                    walk_next     = link_blk;
                    steps_next    = steps_reg + fcfs_pkg::STEP_W'(1);
                    fat_req.raddr = link_blk;
                end else begin
                    cur_next   = walk_reg;
                    scan_next  = '0;
                    svld_next  = 1'b0;
                    state_next = S_ASCAN;
                end
            end

            // Search the last block for its first zero byte, one read per cycle.
            S_ASCAN: begin
                byte_req.raddr = fcfs_pkg::byte_addr(cur_reg, fcfs_pkg::OFS_W'(scan_reg));
                priority if (svld_reg && byte_rdata == '0) begin
                    pos_next   = fcfs_pkg::POS_W'(scan_prev);
                    mode_next  = fcfs_pkg::MODE_APPEND;
                    state_next = S_DONE;
                end else if (scan_reg == fcfs_pkg::SCN_W'(fcfs_pkg::BLOCK_BYTES)) begin
                    pos_next   = fcfs_pkg::POS_W'(fcfs_pkg::BLOCK_BYTES);
                    mode_next  = fcfs_pkg::MODE_APPEND;
                    state_next = S_DONE;
                end else begin
                    scan_next = scan_reg + fcfs_pkg::SCN_W'(1);
                    svld_next = 1'b1;
                end
            end

            // Search the table for the lowest free block.
            S_SCAN: begin
                fat_req.raddr = fcfs_pkg::BLK_W'(scan_reg);
                priority if (svld_reg && fat_q == fcfs_pkg::FAT_FREE) begin
                    walk_next  = fcfs_pkg::BLK_W'(scan_prev);
                    state_next = S_ALLOC;
                end else if (scan_reg == fcfs_pkg::SCN_W'(fcfs_pkg::NUM_BLOCKS)) begin
                    res_status_next = fcfs_pkg::ST_DISK_FULL;
                    if (op_reg != fcfs_pkg::OP_PUT) begin
                        mode_next = fcfs_pkg::MODE_NONE;
                    end
                    state_next = S_DONE;
                end else begin
                    scan_next = scan_reg + fcfs_pkg::SCN_W'(1);
                    svld_next = 1'b1;
                end
            end

            S_ALLOC: begin
                fat_req.we    = 1'b1;
                fat_req.waddr = walk_reg;
                fat_req.wdata = fcfs_pkg::FAT_END;
                scan_next     = '0;
                state_next    = S_CLR;
            end

            // Clear the new block, one byte per cycle.
            S_CLR: begin
                byte_req.we    = 1'b1;
                byte_req.waddr = fcfs_pkg::byte_addr(walk_reg, fcfs_pkg::OFS_W'(scan_reg));
                byte_req.wdata = '0;
                scan_next      = scan_reg + fcfs_pkg::SCN_W'(1);
                if (scan_reg == fcfs_pkg::SCN_W'(fcfs_pkg::BLOCK_BYTES - 1)) begin
                    if (op_reg == fcfs_pkg::OP_PUT) begin
                        state_next = S_LINK;
                    end else begin
                        cur_next   = walk_reg;
                        pos_next   = '0;
                        mode_next  = (op_reg == fcfs_pkg::OP_OPEN_AP) ?
                                     fcfs_pkg::MODE_APPEND : fcfs_pkg::MODE_WRITE;
                        state_next = S_DONE;
                    end
                end
            end

            // Link the new block behind the cursor block and store the byte.
            S_LINK: begin
                fat_req.we     = 1'b1;
                fat_req.waddr  = cur_reg;
                fat_req.wdata  = fcfs_pkg::FAT_W'(walk_reg);
                byte_req.we    = 1'b1;
                byte_req.waddr = fcfs_pkg::byte_addr(walk_reg, '0);
                byte_req.wdata = data_reg;
                cur_next       = walk_reg;
                pos_next       = fcfs_pkg::POS_W'(1);
                state_next     = S_DONE;
            end

            S_PUT_LNK: begin
                if (fcfs_pkg::has_link(fat_q)) begin
                    byte_req.we    = 1'b1;
                    byte_req.waddr = fcfs_pkg::byte_addr(link_blk, '0);
                    byte_req.wdata = data_reg;
                    cur_next       = link_blk;
                    pos_next       = fcfs_pkg::POS_W'(1);
                    state_next     = S_DONE;
                end else begin
                    scan_next  = '0;
                    svld_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_GET_LNK: begin
                if (fcfs_pkg::has_link(fat_q)) begin
                    cur_next       = link_blk;
                    pos_next       = '0;
                    byte_req.raddr = fcfs_pkg::byte_addr(link_blk, '0);
                    state_next     = S_GET_RD;
                end else begin
                    res_status_next = fcfs_pkg::ST_EOF;
                    state_next      = S_DONE;
                end
            end

            S_GET_RD: begin
                res_rb_next = byte_rdata;
                pos_next    = pos_reg + fcfs_pkg::POS_W'(1);
                state_next  = S_DONE;
            end

            // Free the chain one block per cycle.
            S_DEL: begin
                fat_req.we    = 1'b1;
                fat_req.waddr = walk_reg;
                fat_req.wdata = fcfs_pkg::FAT_FREE;
                if (fat_q == fcfs_pkg::FAT_FREE
                        || fat_q >= fcfs_pkg::FAT_W'(fcfs_pkg::NUM_BLOCKS)
                        || fat_q < fcfs_pkg::FAT_W'(fcfs_pkg::RESERVED_BLOCKS)
                        || steps_reg == fcfs_pkg::STEP_W'(fcfs_pkg::NUM_BLOCKS - 1)) begin
                    fat_req.raddr = cur_reg;
                    state_next    = S_DELC;
                end else begin
                    walk_next     = link_blk;
                    steps_next    = steps_reg + fcfs_pkg::STEP_W'(1);
                    fat_req.raddr = link_blk;
                end
            end

            // Close the cursor if its block was freed.
            S_DELC: begin
                if (mode_reg != fcfs_pkg::MODE_NONE && fat_q == fcfs_pkg::FAT_FREE) begin
                    mode_next = fcfs_pkg::MODE_NONE;
                end
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_rb_next     = res_rb_reg;
                    m_blk_next    = (mode_reg != fcfs_pkg::MODE_NONE) ?
                                    fcfs_pkg::START_W'(cur_reg) : '0;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    // Forward a table write that hits the address read in the same cycle.
    assign fwd_vld_next  = fat_req.we && (fat_req.waddr == fat_req.raddr);
    assign fwd_data_next = fat_req.wdata;

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            scan_reg    <= '0;
            svld_reg    <= 1'b0;
            mode_reg    <= fcfs_pkg::MODE_NONE;
            cur_reg     <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            svld_reg    <= svld_next;
            mode_reg    <= mode_next;
            cur_reg     <= cur_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            fwd_vld_reg <= fwd_vld_next;
        end
        op_reg         <= op_next;
        sblk_reg       <= sblk_next;
        data_reg       <= data_next;
        walk_reg       <= walk_next;
        steps_reg      <= steps_next;
        res_status_reg <= res_status_next;
        res_rb_reg     <= res_rb_next;
        m_status_reg   <= m_status_next;
        m_rb_reg       <= m_rb_next;
        m_blk_reg      <= m_blk_next;
        fwd_data_reg   <= fwd_data_next;
    end

endmodule
`default_nettype wire

@@ design/fat_chain_file_stream.sv @@
// Top level of the FAT chain file stream: table memory, byte store and sequencer.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid / s_ready  s_op, s_start_block, s_data_byte
//  m_       out        m_valid / m_ready  m_status, m_read_byte, m_block_number
//
// A put inside a block is accepted together with its byte store write; a get is accepted
// with its read, takes the byte in a read state, and both then load the output register
// once it is free. Crossing into an existing block adds a table read. Allocation scans
// the table and clears the new block; append walks the chain and scans its last block, and
// delete frees one block per cycle. After reset s_ready stays low while the table is
// formatted; a stalled result holds.
`default_nettype none
module fat_chain_file_stream (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [fcfs_pkg::OP_W-1:0]       s_op,
    input  wire logic [fcfs_pkg::START_W-1:0]    s_start_block,
    input  wire logic [fcfs_pkg::BYTE_W-1:0]     s_data_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [fcfs_pkg::STATUS_W-1:0]   m_status,
    output logic      [fcfs_pkg::BYTE_W-1:0]     m_read_byte,
    output logic      [fcfs_pkg::START_W-1:0]    m_block_number
);

    fcfs_pkg::fat_req_t             fat_req;
    fcfs_pkg::byte_req_t            byte_req;
    logic [fcfs_pkg::FAT_W-1:0]     fat_rdata;
    logic [fcfs_pkg::BYTE_W-1:0]    byte_rdata;

    // File allocation table.
    fcfs_ram #(
        .WIDTH(fcfs_pkg::FAT_W),
        .DEPTH(fcfs_pkg::NUM_BLOCKS)
    ) u_fat_ram (
        .aclk  (aclk),
        .we    (fat_req.we),
        .waddr (fat_req.waddr),
        .wdata (fat_req.wdata),
        .raddr (fat_req.raddr),
        .rdata (fat_rdata)
    );

    // Byte store.
    fcfs_ram #(
        .WIDTH(fcfs_pkg::BYTE_W),
        .DEPTH(fcfs_pkg::NUM_BLOCKS * fcfs_pkg::BLOCK_BYTES)
    ) u_byte_ram (
        .aclk  (aclk),
        .we    (byte_req.we),
        .waddr (byte_req.waddr),
        .wdata (byte_req.wdata),
        .raddr (byte_req.raddr),
        .rdata (byte_rdata)
    );

    // Sequencer with cursor state and output register.
    fcfs_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_start_block  (s_start_block),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_read_byte    (m_read_byte),
        .m_block_number (m_block_number),
        .fat_req        (fat_req),
        .fat_rdata      (fat_rdata),
        .byte_req       (byte_req),
        .byte_rdata     (byte_rdata)
    );

endmodule
`default_nettype wire

@@ design/fcfs_checker.sv @@
// Port-level checks of the FAT chain file stream and their bind to the top level.
`default_nettype none
module fcfs_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic [fcfs_pkg::OP_W-1:0]       s_op,
    input wire logic [fcfs_pkg::START_W-1:0]    s_start_block,
    input wire logic [fcfs_pkg::BYTE_W-1:0]     s_data_byte,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [fcfs_pkg::STATUS_W-1:0]   m_status,
    input wire logic [fcfs_pkg::BYTE_W-1:0]     m_read_byte,
    input wire logic [fcfs_pkg::START_W-1:0]    m_block_number
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // One transaction is in work at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    // Only a successful get returns a nonzero byte.
    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_byte != '0 |-> m_status == fcfs_pkg::ST_OK)
        else $error("byte returned with an error status");

    // With no file open, the block number reads zero.
    a_no_file_blk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == fcfs_pkg::ST_NO_FILE |-> m_block_number == '0)
        else $error("block number shown with no file open");

    // Status stays within its defined codes.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= fcfs_pkg::ST_NO_FILE)
        else $error("undefined status code");

endmodule

bind fat_chain_file_stream fcfs_checker u_fcfs_checker (.*);
`default_nettype wire

@@ tb/fat_chain_file_stream_tb.sv @@
// Self-checking testbench of the FAT chain file stream with a queue-fed driver and monitor.
`timescale 1ns / 100ps
`default_nettype none
module fat_chain_file_stream_tb;

    localparam int CLK_PERIOD = 12;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 100;
    localparam logic [fcfs_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [fcfs_pkg::OP_W-1:0]    op;
        logic [fcfs_pkg::START_W-1:0] blk;
        logic [fcfs_pkg::BYTE_W-1:0]  data;
    } file_cmd_t;

    typedef struct packed {
        logic [fcfs_pkg::STATUS_W-1:0] status;
        logic [fcfs_pkg::BYTE_W-1:0]   rbyte;
        logic [fcfs_pkg::START_W-1:0]  blk;
    } file_resp_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [fcfs_pkg::OP_W-1:0]     s_op = '0;
    logic [fcfs_pkg::START_W-1:0]  s_start_block = '0;
    logic [fcfs_pkg::BYTE_W-1:0]   s_data_byte = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [fcfs_pkg::STATUS_W-1:0] m_status;
    logic [fcfs_pkg::BYTE_W-1:0]   m_read_byte;
    logic [fcfs_pkg::START_W-1:0]  m_block_number;

    file_cmd_t  cmd_q[$];
    file_resp_t resp_q[$];
    int         file_q[$];
    int         err_cnt = 0;
    int         idle_cycles = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         quiet_cnt = 0;

    // Shadow copy of the file system state.
    logic [fcfs_pkg::FAT_W-1:0]  fat_shadow[fcfs_pkg::NUM_BLOCKS];
    logic [fcfs_pkg::BYTE_W-1:0] disk_shadow[fcfs_pkg::NUM_BLOCKS*fcfs_pkg::BLOCK_BYTES];
    int                          cur_blk;
    int                          cur_pos;
    fcfs_pkg::mode_t             cur_mode;

    fat_chain_file_stream u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_start_block (s_start_block),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_byte   (m_read_byte),
        .m_block_number(m_block_number)
    );

    // Clock and reset.
    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Returns 1 with the next block when block b links onward.
    function automatic bit next_block(input int b, output int nx);
        logic [fcfs_pkg::FAT_W-1:0] v;
        v = fat_shadow[b];
        nx = 0;
        if (v == fcfs_pkg::FAT_END || v == fcfs_pkg::FAT_FREE || v >= fcfs_pkg::NUM_BLOCKS)
            return 1'b0;
        nx = int'(v);
        return 1'b1;
    endfunction

    // Allocates and clears the lowest free block; NUM_BLOCKS when the disk is full.
    function automatic int alloc_block();
        for (int i = 0; i < fcfs_pkg::NUM_BLOCKS; i++) begin
            if (fat_shadow[i] == fcfs_pkg::FAT_FREE) begin
                fat_shadow[i] = fcfs_pkg::FAT_END;
                for (int p = 0; p < fcfs_pkg::BLOCK_BYTES; p++)
                    disk_shadow[i*fcfs_pkg::BLOCK_BYTES+p] = '0;
                return i;
            end
        end
        return fcfs_pkg::NUM_BLOCKS;
    endfunction

    function automatic fcfs_pkg::status_t open_fresh(input fcfs_pkg::mode_t m);
        int b;
        b = alloc_block();
        if (b >= fcfs_pkg::NUM_BLOCKS) begin
            cur_mode = fcfs_pkg::MODE_NONE;
            return fcfs_pkg::ST_DISK_FULL;
        end
        cur_blk = b;
        cur_pos = 0;
        cur_mode = m;
        return fcfs_pkg::ST_OK;
    endfunction

    // Walks to the last block of the chain and to its first zero byte.
    function automatic void open_at_end(input int s);
        int b;
        int nx;
        int p;
        b = s;
        for (int n = 0; n < fcfs_pkg::NUM_BLOCKS; n++) begin
            if (!next_block(b, nx)) break;
            b = nx;
        end
        for (p = 0; p < fcfs_pkg::BLOCK_BYTES; p++)
            if (disk_shadow[b*fcfs_pkg::BLOCK_BYTES+p] == '0) break;
        cur_blk = b;
        cur_pos = p;
        cur_mode = fcfs_pkg::MODE_APPEND;
    endfunction

    function automatic fcfs_pkg::status_t write_byte(input logic [fcfs_pkg::BYTE_W-1:0] d);
        int nx;
        if (cur_mode == fcfs_pkg::MODE_NONE) return fcfs_pkg::ST_NO_FILE;
        if (cur_mode == fcfs_pkg::MODE_READ) return fcfs_pkg::ST_READ_ONLY;
        if (cur_pos >= fcfs_pkg::BLOCK_BYTES) begin
            if (next_block(cur_blk, nx)) begin
                cur_blk = nx;
            end else begin
                nx = alloc_block();
                if (nx >= fcfs_pkg::NUM_BLOCKS) return fcfs_pkg::ST_DISK_FULL;
                fat_shadow[cur_blk] = fcfs_pkg::FAT_W'(nx);
                cur_blk = nx;
            end
            cur_pos = 0;
        end
        disk_shadow[cur_blk*fcfs_pkg::BLOCK_BYTES+cur_pos] = d;
        cur_pos++;
        return fcfs_pkg::ST_OK;
    endfunction

    function automatic fcfs_pkg::status_t read_byte(output logic [fcfs_pkg::BYTE_W-1:0] rb);
        int nx;
        rb = '0;
        if (cur_mode == fcfs_pkg::MODE_NONE) return fcfs_pkg::ST_NO_FILE;
        if (cur_pos >= fcfs_pkg::BLOCK_BYTES) begin
            if (!next_block(cur_blk, nx)) return fcfs_pkg::ST_EOF;
            cur_blk = nx;
            cur_pos = 0;
        end
        rb = disk_shadow[cur_blk*fcfs_pkg::BLOCK_BYTES+cur_pos];
        cur_pos++;
        return fcfs_pkg::ST_OK;
    endfunction

    // Frees the whole chain; the cursor closes when its block was freed.
    function automatic void free_chain(input int s);
        int b;
        logic [fcfs_pkg::FAT_W-1:0] v;
        if (s < fcfs_pkg::RESERVED_BLOCKS || fat_shadow[s] == fcfs_pkg::FAT_FREE) return;
        b = s;
        for (int n = 0; n < fcfs_pkg::NUM_BLOCKS; n++) begin
            v = fat_shadow[b];
            fat_shadow[b] = fcfs_pkg::FAT_FREE;
            if (v == fcfs_pkg::FAT_FREE || v >= fcfs_pkg::NUM_BLOCKS
                    || v < fcfs_pkg::RESERVED_BLOCKS) break;
            b = int'(v);
        end
        if (cur_mode != fcfs_pkg::MODE_NONE && fat_shadow[cur_blk] == fcfs_pkg::FAT_FREE)
            cur_mode = fcfs_pkg::MODE_NONE;
    endfunction

    // Applies one transaction to the shadow state and returns the response it yields.
    function automatic file_resp_t file_op_result(input file_cmd_t c);
        file_resp_t                  r;
        fcfs_pkg::status_t           st;
        logic [fcfs_pkg::BYTE_W-1:0] rb;
        bit                          found;
        int                          s;
        s = int'(c.blk);
        st = fcfs_pkg::ST_OK;
        rb = '0;
        found = fat_shadow[s] != fcfs_pkg::FAT_FREE;
        case (c.op)
            fcfs_pkg::OP_OPEN_RD: begin
                if (found) begin
                    cur_blk = s; cur_pos = 0; cur_mode = fcfs_pkg::MODE_READ;
                end else begin
                    cur_mode = fcfs_pkg::MODE_NONE; st = fcfs_pkg::ST_NO_FILE;
                end
            end
            fcfs_pkg::OP_OPEN_WR: begin
                if (found) begin
                    cur_blk = s; cur_pos = 0; cur_mode = fcfs_pkg::MODE_WRITE;
                end else begin
                    st = open_fresh(fcfs_pkg::MODE_WRITE);
                end
            end
            fcfs_pkg::OP_OPEN_AP: begin
                if (found) open_at_end(s);
                else st = open_fresh(fcfs_pkg::MODE_APPEND);
            end
            fcfs_pkg::OP_CREATE: st = open_fresh(fcfs_pkg::MODE_WRITE);
            fcfs_pkg::OP_PUT:    st = write_byte(c.data);
            fcfs_pkg::OP_GET:    st = read_byte(rb);
            fcfs_pkg::OP_DELETE: free_chain(s);
            default: ;
        endcase
        r.status = st;
        r.rbyte = rb;
        r.blk = (cur_mode != fcfs_pkg::MODE_NONE) ? fcfs_pkg::START_W'(cur_blk) : '0;
        return r;
    endfunction

    // Queues a transaction unless it would read bytes of a reserved block, which hold no data.
    task automatic issue(input logic [fcfs_pkg::OP_W-1:0] op, input int s,
                         input logic [fcfs_pkg::BYTE_W-1:0] d);
        file_cmd_t  c;
        file_resp_t r;
        if (op == fcfs_pkg::OP_OPEN_AP && s < fcfs_pkg::RESERVED_BLOCKS
                && fat_shadow[s] != fcfs_pkg::FAT_FREE) return;
        if (op == fcfs_pkg::OP_GET && cur_mode != fcfs_pkg::MODE_NONE
                && cur_blk < fcfs_pkg::RESERVED_BLOCKS) return;
        c.op = op;
        c.blk = fcfs_pkg::START_W'(s);
        c.data = d;
        r = file_op_result(c);
        cmd_q.push_back(c);
        resp_q.push_back(r);
        if ((op == fcfs_pkg::OP_CREATE || op == fcfs_pkg::OP_OPEN_WR
                || op == fcfs_pkg::OP_OPEN_AP) && r.status == fcfs_pkg::ST_OK)
            file_q.push_back(cur_blk);
    endtask

    function automatic int pick_file();
        if (file_q.size() == 0 || $urandom_range(0, 7) == 0)
            return $urandom_range(0, fcfs_pkg::NUM_BLOCKS-1);
        return file_q[$urandom_range(0, file_q.size()-1)];
    endfunction

    // Idle length: mostly none or short, now and then long, none at all in quiet stretches.
    function automatic int pick_gap();
        int r;
        if (quiet_cnt > 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Driver: presents queued transactions and holds each until it is accepted.
    always @(posedge aclk) begin
        file_cmd_t c;
        if (quiet_cnt > 0) quiet_cnt--;
        else if ($urandom_range(0, 499) == 0) quiet_cnt = $urandom_range(50, 300);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                c = cmd_q.pop_front();
                s_valid <= 1'b1;
                s_op <= c.op;
                s_start_block <= c.blk;
                s_data_byte <= c.data;
                send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: applies back pressure, checks each response and runs the watchdog.
    always @(posedge aclk) begin
        file_resp_t w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready) recv_gap = pick_gap();
            end
            if (m_valid && m_ready) begin
                if (resp_q.size() == 0) begin
                    $error("unexpected response: status %0d", m_status);
                    err_cnt++;
                end else begin
                    w = resp_q.pop_front();
                    if (m_status !== w.status) begin
                        $error("status: expected %0d, got %0d", w.status, m_status);
                        err_cnt++;
                    end
                    if (m_read_byte !== w.rbyte) begin
                        $error("read_byte: expected %0h, got %0h", w.rbyte, m_read_byte);
                        err_cnt++;
                    end
                    if (m_block_number !== w.blk) begin
                        $error("block_number: expected %0d, got %0d", w.blk, m_block_number);
                        err_cnt++;
                    end
                end
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("fat_chain_file_stream_tb: FAIL");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int f;
        int k;
        int n;
        int cnt;
        foreach (fat_shadow[i]) fat_shadow[i] = fcfs_pkg::FAT_FREE;
        fat_shadow[0] = fcfs_pkg::FAT_END;
        fat_shadow[1] = fcfs_pkg::FAT_W'(2);
        fat_shadow[2] = fcfs_pkg::FAT_END;
        fat_shadow[3] = fcfs_pkg::FAT_END;
        cur_blk = 0;
        cur_pos = 0;
        cur_mode = fcfs_pkg::MODE_NONE;

        // Directed: missing files, closed cursor, read-only, append, reserved blocks, unused op.
        issue(fcfs_pkg::OP_OPEN_RD, 500, 8'h00);
        issue(fcfs_pkg::OP_PUT, 0, 8'hFF);
        issue(fcfs_pkg::OP_GET, 0, 8'h00);
        issue(fcfs_pkg::OP_CREATE, 0, 8'h00);
        f = cur_blk;
        issue(fcfs_pkg::OP_PUT, 0, 8'hFF);
        issue(fcfs_pkg::OP_PUT, 0, 8'h00);
        issue(fcfs_pkg::OP_PUT, 0, 8'hA5);
        issue(fcfs_pkg::OP_OPEN_RD, f, 8'h00);
        issue(fcfs_pkg::OP_GET, 0, 8'h00);
        issue(fcfs_pkg::OP_GET, 0, 8'h00);
        issue(fcfs_pkg::OP_GET, 0, 8'h00);
        issue(fcfs_pkg::OP_PUT, 0, 8'h12);
        issue(fcfs_pkg::OP_OPEN_AP, f, 8'h00);
        issue(fcfs_pkg::OP_PUT, 1023, 8'h5A);
        issue(fcfs_pkg::OP_OPEN_WR, 1023, 8'h00);
        issue(fcfs_pkg::OP_OPEN_AP, 1000, 8'h00);
        issue(fcfs_pkg::OP_DELETE, 2, 8'h00);
        issue(fcfs_pkg::OP_DELETE, 900, 8'h00);
        issue(fcfs_pkg::OP_DELETE, f, 8'h00);
        issue(OP_UNUSED, 1023, 8'hFF);
        issue(fcfs_pkg::OP_OPEN_RD, 1, 8'h00);
        issue(fcfs_pkg::OP_OPEN_WR, 3, 8'h00);
        issue(fcfs_pkg::OP_PUT, 0, 8'h11);
        issue(fcfs_pkg::OP_DELETE, cur_blk, 8'h00);

        // One full block: end of file, append at a full block, a new block taken by put.
        issue(fcfs_pkg::OP_CREATE, 0, 8'h00);
        f = cur_blk;
        for (int i = 0; i < fcfs_pkg::BLOCK_BYTES; i++)
            issue(fcfs_pkg::OP_PUT, 0, 8'($urandom_range(1, 255)));
        issue(fcfs_pkg::OP_GET, 0, 8'h00);
        issue(fcfs_pkg::OP_OPEN_AP, f, 8'h00);
        issue(fcfs_pkg::OP_GET, 0, 8'h00);
        issue(fcfs_pkg::OP_PUT, 0, 8'h77);
        issue(fcfs_pkg::OP_PUT, 0, 8'h78);
        issue(fcfs_pkg::OP_OPEN_AP, f, 8'h00);
        issue(fcfs_pkg::OP_PUT, 0, 8'h79);
        issue(fcfs_pkg::OP_OPEN_RD, f, 8'h00);
        for (int i = 0; i < 4; i++) issue(fcfs_pkg::OP_GET, 0, 8'h00);
        issue(fcfs_pkg::OP_DELETE, f, 8'h00);

        // Random sessions: opens followed by byte traffic, creates, deletes and noise.
        cnt = 0;
        while (cnt < RANDOM_ITEMS) begin
            k = $urandom_range(0, 99);
            n = $urandom_range(1, 20);
            if (k < 35) begin
                issue(3'(fcfs_pkg::OP_OPEN_RD + $urandom_range(0, 2)), pick_file(), 8'h00);
            end else if (k < 50) begin
                issue(fcfs_pkg::OP_CREATE, $urandom_range(0, fcfs_pkg::NUM_BLOCKS-1),
                      8'($urandom_range(0, 255)));
                n = $urandom_range(1, 30);
            end else if (k < 62) begin
                issue(fcfs_pkg::OP_DELETE, pick_file(), 8'($urandom_range(0, 255)));
                n = 0;
            end else if (k < 80) begin
                issue(3'($urandom_range(0, 7)), $urandom_range(0, fcfs_pkg::NUM_BLOCKS-1),
                      8'($urandom_range(0, 255)));
                n = 0;
            end
            cnt += n + 1;
            for (int i = 0; i < n; i++)
                issue($urandom_range(0, 2) == 0 ? fcfs_pkg::OP_GET : fcfs_pkg::OP_PUT,
                      $urandom_range(0, fcfs_pkg::NUM_BLOCKS-1), 8'($urandom_range(0, 255)));
        end

        while (cmd_q.size() > 0 || resp_q.size() > 0 || s_valid) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("fat_chain_file_stream_tb: PASS");
        end else begin
            $display("fat_chain_file_stream_tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
